[hw/rtl/tcm_pkg.sv]
// tcm_pkg: shared types and constants of the touch calibrate and map unit.
// No dependencies; used by tcm_datapath, tcm_controller and the top level.
package tcm_pkg;

    localparam int RAW_W     = 13;
    localparam int RAW_MAX   = 8191;
    localparam int SCR_W     = 9;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd3;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CAPTURE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd3;

    localparam logic [1:0] LAST_CORNER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } tcm_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic div_capture;
        logic axis;
        logic commit;
    } tcm_cmd_t;

    typedef struct packed {
        logic is_read;
        logic touched;
        logic tally_zero;
        logic div_done;
        logic out_free;
    } tcm_status_t;

endpackage

[hw/rtl/tcm_divider.sv]
// tcm_divider: unsigned restoring divider, one quotient bit per cycle.
// No package dependency; instantiated by tcm_datapath.
module tcm_divider #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_diff;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/tcm_datapath.sv]
// tcm_datapath: item registers, accumulators, corner store, limits, mapper
// multiply, shared divider and output register. Uses tcm_pkg, tcm_divider.
module tcm_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_SAMPLES   = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcm_pkg::tcm_cmd_t                   cmd,
    output tcm_pkg::tcm_status_t                status,
    input  logic                                command,
    input  logic                                touched,
    input  logic [7:0]                          x_high_byte,
    input  logic [7:0]                          x_low_byte,
    input  logic [7:0]                          y_high_byte,
    input  logic [7:0]                          y_low_byte,
    input  logic                                cfg_write,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcm_pkg::RAW_W-1:0]           cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcm_pkg::KIND_W-1:0]          kind,
    output logic [tcm_pkg::SCR_W-1:0]           screen_x,
    output logic [tcm_pkg::SCR_W-1:0]           screen_y,
    output logic                                pressed,
    output logic [1:0]                          point_number,
    output logic [tcm_pkg::RAW_W-1:0]           mean_x,
    output logic [tcm_pkg::RAW_W-1:0]           mean_y
);

    localparam int RAW_W   = tcm_pkg::RAW_W;
    localparam int SCR_W   = tcm_pkg::SCR_W;
    localparam int RES_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int RES_W   = $clog2(RES_MAX);
    localparam int MAG_W   = RAW_W + RES_W;
    localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
    localparam int ACC_W   = $clog2(MAX_SAMPLES * tcm_pkg::RAW_MAX + 1);
    localparam int DVD_W   = (ACC_W > MAG_W) ? ACC_W : MAG_W;
    localparam int DVS_W   = (TALLY_W > RAW_W) ? TALLY_W : RAW_W;

    // item
    logic             cmd_reg;
    logic             touched_reg;
    logic [RAW_W-1:0] rx_reg;
    logic [RAW_W-1:0] ry_reg;

    // configuration and calibration state
    logic [RAW_W-1:0]   stored_reg [4];
    logic [RAW_W-1:0]   learned_reg [4];
    logic [RAW_W-1:0]   corner_x_reg [4];
    logic [RAW_W-1:0]   corner_y_reg [4];
    logic [ACC_W-1:0]   acc_x_reg;
    logic [ACC_W-1:0]   acc_y_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [1:0]         corner_idx_reg;
    logic               calibrated_reg;

    // work registers
    logic [MAG_W-1:0] prod_mag_reg, prod_mag_next;
    logic             prod_neg_reg;
    logic [SCR_W-1:0] map_x_reg, map_y_reg;
    logic [RAW_W-1:0] mx_reg, my_reg;

    // output register
    logic                      out_valid_reg;
    logic [tcm_pkg::KIND_W-1:0] kind_reg;
    logic [SCR_W-1:0]          sx_reg, sy_reg;
    logic                      pressed_reg;
    logic [1:0]                point_reg;
    logic [RAW_W-1:0]          mean_x_reg, mean_y_reg;

    logic [RAW_W-1:0] lo_sel, hi_sel, raw_sel;
    logic [RES_W-1:0] res_m1_sel;
    logic [DVD_W-1:0] res_dvd, res_m1_dvd;
    logic [RAW_W:0]   diff, diff_abs, rdiff, rdiff_abs;
    logic [RAW_W-1:0] range_mag;
    logic             range_neg;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic             div_done;
    logic [DVD_W-1:0] quo;
    logic [SCR_W-1:0] map_val;
    logic             map_neg;
    logic             tally_room;
    logic [RAW_W-1:0] lx_min, lx_max, ly_min, ly_max;

    // axis selection
    always_comb
    begin
        if (cmd.axis)
        begin
            raw_sel    = ry_reg;
            lo_sel     = calibrated_reg ? learned_reg[2] : stored_reg[2];
            hi_sel     = calibrated_reg ? learned_reg[3] : stored_reg[3];
            res_m1_sel = RES_W'(SCREEN_HEIGHT - 1);
            res_dvd    = DVD_W'(SCREEN_HEIGHT);
            res_m1_dvd = DVD_W'(SCREEN_HEIGHT - 1);
        end
        else
        begin
            raw_sel    = rx_reg;
            lo_sel     = calibrated_reg ? learned_reg[0] : stored_reg[0];
            hi_sel     = calibrated_reg ? learned_reg[1] : stored_reg[1];
            res_m1_sel = RES_W'(SCREEN_WIDTH - 1);
            res_dvd    = DVD_W'(SCREEN_WIDTH);
            res_m1_dvd = DVD_W'(SCREEN_WIDTH - 1);
        end
    end

    assign diff          = {1'b0, raw_sel} - {1'b0, lo_sel};
    assign diff_abs      = diff[RAW_W] ? ((RAW_W+1)'(0) - diff) : diff;
    assign prod_mag_next = {{RES_W{1'b0}}, diff_abs[RAW_W-1:0]} * {{RAW_W{1'b0}}, res_m1_sel};

    assign rdiff     = {1'b0, hi_sel} - {1'b0, lo_sel};
    assign range_neg = rdiff[RAW_W];
    assign rdiff_abs = range_neg ? ((RAW_W+1)'(0) - rdiff) : rdiff;
    assign range_mag = (rdiff_abs == '0) ? RAW_W'(1) : rdiff_abs[RAW_W-1:0];

    assign dvd = (cmd_reg == tcm_pkg::CMD_READ) ? DVD_W'(prod_mag_reg)
               : (cmd.axis ? DVD_W'(acc_y_reg) : DVD_W'(acc_x_reg));
    assign dvs = (cmd_reg == tcm_pkg::CMD_READ) ? DVS_W'(range_mag) : DVS_W'(tally_reg);

    tcm_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // signed truncating quotient clamped to the screen
    assign map_neg = prod_neg_reg ^ range_neg;
    always_comb
    begin
        if (map_neg)
        begin
            map_val = '0;
        end
        else if (quo >= res_dvd)
        begin
            map_val = res_m1_dvd[SCR_W-1:0];
        end
        else
        begin
            map_val = quo[SCR_W-1:0];
        end
    end

    assign tally_room = tally_reg < TALLY_W'(MAX_SAMPLES);

    assign lx_min = (corner_x_reg[0] < mx_reg) ? corner_x_reg[0] : mx_reg;
    assign lx_max = (corner_x_reg[1] > corner_x_reg[2]) ? corner_x_reg[1] : corner_x_reg[2];
    assign ly_min = (corner_y_reg[0] < corner_y_reg[1]) ? corner_y_reg[0] : corner_y_reg[1];
    assign ly_max = (corner_y_reg[2] > my_reg) ? corner_y_reg[2] : my_reg;

    // item, work and corner registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= command;
            touched_reg <= touched;
            rx_reg      <= {x_high_byte, x_low_byte[7:3]};
            ry_reg      <= {y_high_byte, y_low_byte[7:3]};
        end
        if (cmd.mul)
        begin
            prod_mag_reg <= prod_mag_next;
            prod_neg_reg <= diff[RAW_W];
        end
        if (cmd.div_capture)
        begin
            if (cmd.axis)
            begin
                map_y_reg <= map_val;
                my_reg    <= quo[RAW_W-1:0];
            end
            else
            begin
                map_x_reg <= map_val;
                mx_reg    <= quo[RAW_W-1:0];
            end
        end
        if (cmd.commit && cmd_reg == tcm_pkg::CMD_TICK && !touched_reg && tally_reg != '0)
        begin
            corner_x_reg[corner_idx_reg] <= mx_reg;
            corner_y_reg[corner_idx_reg] <= my_reg;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg[0] <= '0;
            stored_reg[1] <= RAW_W'(tcm_pkg::RAW_MAX);
            stored_reg[2] <= '0;
            stored_reg[3] <= RAW_W'(tcm_pkg::RAW_MAX);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tcm_pkg::CFG_X_MIN: stored_reg[0] <= cfg_data;
                tcm_pkg::CFG_X_MAX: stored_reg[1] <= cfg_data;
                tcm_pkg::CFG_Y_MIN: stored_reg[2] <= cfg_data;
                tcm_pkg::CFG_Y_MAX: stored_reg[3] <= cfg_data;
            endcase
        end
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            tally_reg      <= '0;
            corner_idx_reg <= '0;
            calibrated_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                learned_reg[i] <= '0;
            end
        end
        else if (cmd.commit && cmd_reg == tcm_pkg::CMD_TICK)
        begin
            if (touched_reg)
            begin
                if (tally_room)
                begin
                    acc_x_reg <= acc_x_reg + ACC_W'(rx_reg);
                    acc_y_reg <= acc_y_reg + ACC_W'(ry_reg);
                    tally_reg <= tally_reg + TALLY_W'(1);
                end
            end
            else if (tally_reg != '0)
            begin
                acc_x_reg      <= '0;
                acc_y_reg      <= '0;
                tally_reg      <= '0;
                corner_idx_reg <= corner_idx_reg + 2'd1;
                if (corner_idx_reg == tcm_pkg::LAST_CORNER)
                begin
                    learned_reg[0] <= lx_min;
                    learned_reg[1] <= lx_max;
                    learned_reg[2] <= ly_min;
                    learned_reg[3] <= ly_max;
                    calibrated_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sx_reg      <= '0;
            sy_reg      <= '0;
            pressed_reg <= 1'b0;
            point_reg   <= '0;
            mean_x_reg  <= '0;
            mean_y_reg  <= '0;
            if (cmd_reg == tcm_pkg::CMD_READ)
            begin
                kind_reg    <= tcm_pkg::KIND_POSITION;
                sx_reg      <= map_x_reg;
                sy_reg      <= map_y_reg;
                pressed_reg <= touched_reg;
            end
            else if (touched_reg || tally_reg == '0)
            begin
                kind_reg <= tcm_pkg::KIND_IDLE;
            end
            else
            begin
                kind_reg   <= (corner_idx_reg == tcm_pkg::LAST_CORNER)
                              ? tcm_pkg::KIND_COMPLETE : tcm_pkg::KIND_CAPTURE;
                point_reg  <= corner_idx_reg;
                mean_x_reg <= mx_reg;
                mean_y_reg <= my_reg;
            end
        end
    end

    assign status.is_read    = (cmd_reg == tcm_pkg::CMD_READ);
    assign status.touched    = touched_reg;
    assign status.tally_zero = (tally_reg == '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign pressed      = pressed_reg;
    assign point_number = point_reg;
    assign mean_x       = mean_x_reg;
    assign mean_y       = mean_y_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed item not presented");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= TALLY_W'(MAX_SAMPLES))
        else $error("sample count above limit");

    a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd_reg == tcm_pkg::CMD_TICK && !touched_reg && tally_reg != '0)
        |=> (tally_reg == '0 && acc_x_reg == '0 && acc_y_reg == '0))
        else $error("accumulators not cleared after capture");

    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated_reg |=> calibrated_reg)
        else $error("calibrated flag dropped");

endmodule

[hw/rtl/tcm_controller.sv]
// tcm_controller: sequencing state machine of the touch calibrate and map unit.
// Uses tcm_pkg; drives tcm_datapath through tcm_cmd_t.
module tcm_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output tcm_pkg::tcm_cmd_t    cmd,
    input  tcm_pkg::tcm_status_t status
);

    tcm_pkg::tcm_state_t state_reg, state_next;
    logic                axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tcm_pkg::ST_DECIDE;
                end
            end
            tcm_pkg::ST_DECIDE:
            begin
                priority if (status.is_read)
                begin
                    state_next = tcm_pkg::ST_MUL;
                end
                else if (status.touched || status.tally_zero)
                begin
                    state_next = tcm_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = tcm_pkg::ST_DIV_GO;
                end
            end
            tcm_pkg::ST_MUL:
            begin
                state_next = tcm_pkg::ST_DIV_GO;
            end
            tcm_pkg::ST_DIV_GO:
            begin
                state_next = tcm_pkg::ST_DIV_WAIT;
            end
            tcm_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    priority if (axis_reg)
                    begin
                        state_next = tcm_pkg::ST_FINISH;
                    end
                    else if (status.is_read)
                    begin
                        state_next = tcm_pkg::ST_MUL;
                    end
                    else
                    begin
                        state_next = tcm_pkg::ST_DIV_GO;
                    end
                end
            end
            tcm_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = tcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        axis_next       = axis_reg;
        cmd.load        = 1'b0;
        cmd.mul         = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.div_capture = 1'b0;
        cmd.commit      = 1'b0;
        in_stall        = 1'b1;
        unique case (state_reg)
            tcm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            tcm_pkg::ST_DECIDE:
            begin
                axis_next = 1'b0;
            end
            tcm_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            tcm_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
            end
            tcm_pkg::ST_DIV_WAIT:
            begin
                cmd.div_capture = status.div_done;
                if (status.div_done)
                begin
                    axis_next = 1'b1;
                end
            end
            tcm_pkg::ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        cmd.axis = axis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcm_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

[hw/rtl/touch_calibrate_and_map_unit.sv]
// touch_calibrate_and_map_unit: top level, four-corner touch calibration and
// raw-to-screen mapping. Uses tcm_pkg, tcm_controller, tcm_datapath.
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------
//   in      | in_valid / in_stall       | command, touched, x/y high/low bytes
//   out     | out_valid / out_stall     | kind, screen_x/y, pressed, point, means
//   cfg     | cfg_write, cfg_index      | cfg_data (13 bit raw limit)
//
// One item at a time. A position read does a multiply and a divide per axis,
// a corner capture a divide per axis and any other tick neither. The shared
// serial divider has a D-bit dividend, D = max(accumulator width, 13 + screen
// coordinate width) (23 at the default sizes). The next item is taken while the
// last result still waits in the output register; a result stalls the unit
// only when the following one is ready. Reset is asynchronous, active low.
module touch_calibrate_and_map_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_SAMPLES   = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic                          touched,
    input  logic [7:0]                    x_high_byte,
    input  logic [7:0]                    x_low_byte,
    input  logic [7:0]                    y_high_byte,
    input  logic [7:0]                    y_low_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcm_pkg::KIND_W-1:0]    kind,
    output logic [tcm_pkg::SCR_W-1:0]     screen_x,
    output logic [tcm_pkg::SCR_W-1:0]     screen_y,
    output logic                          pressed,
    output logic [1:0]                    point_number,
    output logic [tcm_pkg::RAW_W-1:0]     mean_x,
    output logic [tcm_pkg::RAW_W-1:0]     mean_y,
    input  logic                          cfg_write,
    input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcm_pkg::RAW_W-1:0]     cfg_data
);

    tcm_pkg::tcm_cmd_t    cmd;
    tcm_pkg::tcm_status_t status;

    tcm_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    tcm_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_SAMPLES   (MAX_SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .command      (command),
        .touched      (touched),
        .x_high_byte  (x_high_byte),
        .x_low_byte   (x_low_byte),
        .y_high_byte  (y_high_byte),
        .y_low_byte   (y_low_byte),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .pressed      (pressed),
        .point_number (point_number),
        .mean_x       (mean_x),
        .mean_y       (mean_y)
    );

endmodule
